// ----- sv/wat_pkg.sv -----
// shared types and constants of the weekly alarm table matcher
// no dependencies; imported by every module of the block
package wat_pkg;

    // table capacity and derived widths
    localparam int MAX_ALARMS = 16;
    localparam int IDX_W      = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CNT_W      = 7;
    localparam int SLOT_W     = 6;
    localparam int MIN_W      = 6;
    localparam int HOUR_W     = 5;
    localparam int DAYS_W     = 7;
    localparam int ACT_W      = 12;

    // marker for "no minute checked yet"
    localparam logic [CNT_W-1:0] NONE_CHECKED = 7'h7f;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_FIRED  = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    // one stored alarm, packed as in the table word
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              rpt;
        logic              active;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic [DAYS_W-1:0] days;
    } entry_t;

    // one result beat
    typedef struct packed {
        kind_t             kind;
        logic              ok;
        logic [SLOT_W-1:0] slot;
        entry_t            entry;
        logic [CNT_W-1:0]  count;
        logic              last;
    } res_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic start_scan;
        logic op_emit;
        logic scan_run;
        logic flush_emit;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic tick_same;
        logic out_free;
        logic scan_done;
        logic pend_valid;
    } dp_status_t;

endpackage

// ----- sv/weekly_alarm_table_matcher.sv -----
// Weekly alarm table matcher. An add, update or read beat is captured and its status beat
// is registered once the output side is free. A tick whose minute equals the last checked
// minute gives no beat. Any other tick scans the held entries (up to 16) one per cycle through
// the single read port of the table, pausing while a match waits on a stalled output side;
// each fired alarm is held back one match so the final one can carry last. The table needs
// no clearing after reset: the data of slots at or above the held count is never used. New
// input is taken only between items.
// top level: wires wat_ctrl and wat_dp; depends on wat_pkg
module weekly_alarm_table_matcher
    import wat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic [SLOT_W-1:0] entry_index,
    input  logic [DAYS_W-1:0] entry_days_mask,
    input  logic [HOUR_W-1:0] entry_hour,
    input  logic [MIN_W-1:0]  entry_minute,
    input  logic              entry_active,
    input  logic              entry_repeat,
    input  logic [ACT_W-1:0]  entry_action,
    input  logic [MIN_W-1:0]  now_minute,
    input  logic [HOUR_W-1:0] now_hour,
    input  logic [2:0]        now_weekday,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        result_kind,
    output logic              ok,
    output logic [SLOT_W-1:0] slot,
    output logic [DAYS_W-1:0] out_days_mask,
    output logic [HOUR_W-1:0] out_hour,
    output logic [MIN_W-1:0]  out_minute,
    output logic              out_active,
    output logic              out_repeat,
    output logic [ACT_W-1:0]  out_action,
    output logic [CNT_W-1:0]  entry_count,
    output logic              last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    res_t       out_res;

    wat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd)
    );

    wat_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .entry_days_mask (entry_days_mask),
        .entry_hour      (entry_hour),
        .entry_minute    (entry_minute),
        .entry_active    (entry_active),
        .entry_repeat    (entry_repeat),
        .entry_action    (entry_action),
        .now_minute      (now_minute),
        .now_hour        (now_hour),
        .now_weekday     (now_weekday),
        .out_ready       (out_ready),
        .out_res         (out_res),
        .out_valid       (out_valid)
    );

    // result beat fields
    assign result_kind   = out_res.kind;
    assign ok            = out_res.ok;
    assign slot          = out_res.slot;
    assign out_days_mask = out_res.entry.days;
    assign out_hour      = out_res.entry.hour;
    assign out_minute    = out_res.entry.minute;
    assign out_active    = out_res.entry.active;
    assign out_repeat    = out_res.entry.rpt;
    assign out_action    = out_res.entry.action;
    assign entry_count   = out_res.count;
    assign last          = out_res.last;

    // held count never exceeds the table capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= CNT_W'(MAX_ALARMS)))
        else $error("entry count above capacity");

    // a fired alarm always reports success
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == KIND_FIRED)) |-> ok)
        else $error("fired alarm without ok");

    // a fired one-shot alarm is reported already deactivated
    a_oneshot_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == KIND_FIRED) && !out_repeat) |-> !out_active)
        else $error("one-shot alarm still active after firing");

    // an add, update or read beat blocks input until its status is issued
    a_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode != OP_TICK)) |=> !in_ready)
        else $error("input taken while an operation is pending");

endmodule

// ----- sv/wat_dp.sv -----
// datapath: alarm table memory, scan pipeline, pending and output registers
// depends on wat_pkg; driven by wat_ctrl commands
module wat_dp
    import wat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic [1:0]        opcode,
    input  logic [SLOT_W-1:0] entry_index,
    input  logic [DAYS_W-1:0] entry_days_mask,
    input  logic [HOUR_W-1:0] entry_hour,
    input  logic [MIN_W-1:0]  entry_minute,
    input  logic              entry_active,
    input  logic              entry_repeat,
    input  logic [ACT_W-1:0]  entry_action,
    input  logic [MIN_W-1:0]  now_minute,
    input  logic [HOUR_W-1:0] now_hour,
    input  logic [2:0]        now_weekday,
    input  logic              out_ready,
    output res_t              out_res,
    output logic              out_valid
);

    entry_t mem [MAX_ALARMS];

    // captured beat
    opcode_t           in_op_reg, in_op_next;
    logic [SLOT_W-1:0] in_idx_reg, in_idx_next;
    entry_t            in_entry_reg, in_entry_next;

    // time of the current scan
    logic [MIN_W-1:0]  now_min_reg, now_min_next;
    logic [HOUR_W-1:0] now_hour_reg, now_hour_next;
    logic [DAYS_W-1:0] daybit_reg, daybit_next;

    // control state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  lcm_reg, lcm_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              pend_vld_reg, pend_vld_next;
    logic              out_vld_reg, out_vld_next;

    // read side and result holding
    entry_t            rd_data_reg;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    res_t              pend_reg, pend_next;
    res_t              out_reg, out_next;

    entry_t            new_entry;
    entry_t            fired_entry;
    res_t              op_res;
    res_t              fire_res;
    logic              idx_ok, room, out_free, hit, stall, advance, scan_more;
    logic              we, re, re_cap;
    logic [IDX_W-1:0]  waddr, raddr;
    entry_t            wdata;

    // entry from the input fields
    always_comb
    begin
        new_entry.action = entry_action;
        new_entry.rpt    = entry_repeat;
        new_entry.active = entry_active;
        new_entry.minute = entry_minute;
        new_entry.hour   = entry_hour;
        new_entry.days   = entry_days_mask;
    end

    // index and capacity checks, scan match
    assign idx_ok    = {1'b0, in_idx_reg} < count_reg;
    assign room      = count_reg < CNT_W'(MAX_ALARMS);
    assign out_free  = !out_vld_reg || out_ready;
    assign scan_more = scan_idx_reg < count_reg;
    assign hit       = rd_vld_reg && rd_data_reg.active
                       && (|(rd_data_reg.days & daybit_reg))
                       && (rd_data_reg.minute == now_min_reg)
                       && (rd_data_reg.hour == now_hour_reg);
    assign stall     = hit && pend_vld_reg && !out_free;
    assign advance   = cmd.scan_run && !stall;

    // one-shot alarm loses its active bit on firing
    always_comb
    begin
        fired_entry        = rd_data_reg;
        fired_entry.active = rd_data_reg.rpt;
    end

    always_comb
    begin
        fire_res.kind  = KIND_FIRED;
        fire_res.ok    = 1'b1;
        fire_res.slot  = rd_slot_reg;
        fire_res.entry = fired_entry;
        fire_res.count = count_reg;
        fire_res.last  = 1'b0;
    end

    // status result of add, update and read
    always_comb
    begin
        op_res.kind  = KIND_READ;
        op_res.ok    = 1'b0;
        op_res.slot  = in_idx_reg;
        op_res.entry = '0;
        op_res.count = count_reg;
        op_res.last  = 1'b1;
        case (in_op_reg)
            OP_ADD:
            begin
                op_res.kind = KIND_ADD;
                op_res.ok   = room;
                op_res.slot = room ? count_reg[SLOT_W-1:0] : '0;
                if (room)
                begin
                    op_res.entry = in_entry_reg;
                    op_res.count = count_reg + 1'b1;
                end
            end
            OP_UPDATE:
            begin
                op_res.kind  = KIND_UPDATE;
                op_res.ok    = idx_ok;
                op_res.entry = idx_ok ? in_entry_reg : '0;
            end
            OP_READ:
            begin
                op_res.kind  = KIND_READ;
                op_res.ok    = idx_ok;
                op_res.entry = idx_ok ? rd_data_reg : '0;
            end
            default:
            begin
                op_res.kind = KIND_FIRED;
                op_res.slot = '0;
            end
        endcase
    end

    // single write port of the table
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = in_entry_reg;
        if (cmd.op_emit && (in_op_reg == OP_ADD) && room)
        begin
            we    = 1'b1;
            waddr = count_reg[IDX_W-1:0];
        end
        else if (cmd.op_emit && (in_op_reg == OP_UPDATE) && idx_ok)
        begin
            we    = 1'b1;
            waddr = in_idx_reg[IDX_W-1:0];
        end
        else if (advance && hit && !rd_data_reg.rpt)
        begin
            we    = 1'b1;
            waddr = rd_slot_reg[IDX_W-1:0];
            wdata = fired_entry;
        end
    end

    // single read port: input index at capture, otherwise the scan
    assign re_cap = cmd.capture && ({1'b0, entry_index} < CNT_W'(MAX_ALARMS));
    assign re     = re_cap || (advance && scan_more);
    assign raddr  = cmd.capture ? entry_index[IDX_W-1:0] : scan_idx_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // next state of datapath registers
    always_comb
    begin
        in_op_next    = in_op_reg;
        in_idx_next   = in_idx_reg;
        in_entry_next = in_entry_reg;
        now_min_next  = now_min_reg;
        now_hour_next = now_hour_reg;
        daybit_next   = daybit_reg;
        count_next    = count_reg;
        lcm_next      = lcm_reg;
        scan_idx_next = scan_idx_reg;
        rd_vld_next   = rd_vld_reg;
        rd_slot_next  = rd_slot_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;

        if (out_ready)
        begin
            out_vld_next = 1'b0;
        end

        if (cmd.capture)
        begin
            in_op_next    = opcode_t'(opcode);
            in_idx_next   = entry_index;
            in_entry_next = new_entry;
        end

        // tick with a new minute starts a scan
        if (cmd.start_scan)
        begin
            lcm_next      = {1'b0, now_minute};
            now_min_next  = now_minute;
            now_hour_next = now_hour;
            daybit_next   = (now_weekday == 3'd0) ? '0
                            : DAYS_W'(1) << (now_weekday - 3'd1);
            scan_idx_next = '0;
            rd_vld_next   = 1'b0;
        end

        if (cmd.op_emit)
        begin
            out_next     = op_res;
            out_vld_next = 1'b1;
            if ((in_op_reg == OP_ADD) && room)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        // scan pipeline: read one entry, evaluate the previous
        if (advance)
        begin
            rd_vld_next = scan_more;
            if (scan_more)
            begin
                rd_slot_next  = scan_idx_reg[SLOT_W-1:0];
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            if (hit)
            begin
                if (pend_vld_reg)
                begin
                    out_next     = pend_reg;
                    out_vld_next = 1'b1;
                end
                pend_next     = fire_res;
                pend_vld_next = 1'b1;
            end
        end

        // final fired alarm carries last
        if (cmd.flush_emit)
        begin
            out_next      = pend_reg;
            out_next.last = 1'b1;
            out_vld_next  = 1'b1;
            pend_vld_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            lcm_reg      <= NONE_CHECKED;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            lcm_reg      <= lcm_next;
            scan_idx_reg <= scan_idx_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_op_reg    <= in_op_next;
        in_idx_reg   <= in_idx_next;
        in_entry_reg <= in_entry_next;
        now_min_reg  <= now_min_next;
        now_hour_reg <= now_hour_next;
        daybit_reg   <= daybit_next;
        rd_slot_reg  <= rd_slot_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    // status back to the controller
    always_comb
    begin
        status.tick_same  = ({1'b0, now_minute} == lcm_reg);
        status.out_free   = out_free;
        status.scan_done  = !rd_vld_reg && !scan_more;
        status.pend_valid = pend_vld_reg;
    end

    assign out_res   = out_reg;
    assign out_valid = out_vld_reg;

endmodule

// ----- sv/wat_ctrl.sv -----
// controller state machine: sequences operations and table scans
// depends on wat_pkg; commands wat_dp
module wat_ctrl
    import wat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_OP    = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (opcode_t'(opcode) == OP_TICK)
                    begin
                        if (!status.tick_same)
                        begin
                            cmd.start_scan = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = ST_OP;
                    end
                end
            end
            ST_OP:
            begin
                if (status.out_free)
                begin
                    cmd.op_emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush_emit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
